// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked at every rising clock edge, ignored while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising clock edge, during reset too.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLKD(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// ----- src/xeu_pkg.sv -----
`timescale 1ns / 1ps

package xeu_pkg;

  // Largest number of output bytes that one input byte can cause.
  localparam int unsigned MaxOut = 10;
  localparam int unsigned LenW = 4;

  // Escape mode codes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_STD  = 2'd1;
  localparam logic [1:0] MODE_ATTR = 2'd2;
  localparam logic [1:0] MODE_CHAR = 2'd3;

  // Characters that may be escaped.
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;

  // A block of output bytes, element 0 goes out first.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [LenW-1:0]        len;
  } xeu_burst_t;

  // Entity lookup result, text element 0 is the first character.
  typedef struct packed {
    logic            hit;
    logic [2:0]      len;
    logic [5:0][7:0] text;
  } xeu_entity_t;

  // Upper byte of the two-byte UTF-8 form of a Latin-1 byte at or above 0x80.
  function automatic logic [7:0] latin1_hi(input logic [7:0] b);
    latin1_hi = {6'b110000, b[7:6]};
  endfunction

  // Lower byte of the two-byte UTF-8 form of a Latin-1 byte.
  function automatic logic [7:0] latin1_lo(input logic [7:0] b);
    latin1_lo = {2'b10, b[5:0]};
  endfunction

  // Returns the entity text for a byte under the given mode, if it is escaped.
  function automatic xeu_entity_t entity_for(input logic [1:0] mode, input logic [7:0] b);
    xeu_entity_t e;
    logic        en_amp;
    logic        en_lt;
    logic        en_gt;
    logic        en_apos;
    logic        en_quot;
    en_amp  = (mode != MODE_NONE);
    en_lt   = (mode != MODE_NONE);
    en_gt   = (mode == MODE_STD);
    en_apos = (mode == MODE_STD);
    en_quot = (mode == MODE_STD) || (mode == MODE_ATTR);
    e.hit  = 1'b0;
    e.len  = 3'd0;
    e.text = '0;
    if (en_amp && b == CH_AMP) begin
      e.hit = 1'b1;
      e.len = 3'd5;
      e.text[0] = 8'h26; e.text[1] = 8'h61; e.text[2] = 8'h6D;
      e.text[3] = 8'h70; e.text[4] = 8'h3B;
    end else if (en_apos && b == CH_APOS) begin
      e.hit = 1'b1;
      e.len = 3'd6;
      e.text[0] = 8'h26; e.text[1] = 8'h61; e.text[2] = 8'h70;
      e.text[3] = 8'h6F; e.text[4] = 8'h73; e.text[5] = 8'h3B;
    end else if (en_lt && b == CH_LT) begin
      e.hit = 1'b1;
      e.len = 3'd4;
      e.text[0] = 8'h26; e.text[1] = 8'h6C; e.text[2] = 8'h74; e.text[3] = 8'h3B;
    end else if (en_gt && b == CH_GT) begin
      e.hit = 1'b1;
      e.len = 3'd4;
      e.text[0] = 8'h26; e.text[1] = 8'h67; e.text[2] = 8'h74; e.text[3] = 8'h3B;
    end else if (en_quot && b == CH_QUOT) begin
      e.hit = 1'b1;
      e.len = 3'd6;
      e.text[0] = 8'h26; e.text[1] = 8'h71; e.text[2] = 8'h75;
      e.text[3] = 8'h6F; e.text[4] = 8'h74; e.text[5] = 8'h3B;
    end
    return e;
  endfunction

endpackage

// ----- src/xeu_expand.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Turns one registered input byte into its block of output bytes and keeps
// the pending UTF-8 sequence between bytes.
module xeu_expand import xeu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic [1:0] mode,
  input  logic       take,
  output xeu_burst_t burst
);

  // Pending sequence: lead, first continuation, and how many bytes remain.
  logic [7:0] held_lead;
  logic [7:0] held_cont;
  logic       cont_held;
  logic [1:0] awaited;

  logic [7:0] held_lead_next;
  logic [7:0] held_cont_next;
  logic       cont_held_next;
  logic [1:0] awaited_next;

  xeu_entity_t     ent;
  logic            pending;
  logic            is_cont;
  logic            complete;
  logic            absorb;
  logic            flush;
  logic            new_lead2;
  logic            new_lead3;
  logic [3:0][7:0] pre;
  logic [2:0]      pre_len;
  logic [5:0][7:0] seg;
  logic [2:0]      seg_len;
  logic [LenW-1:0] j;

  // Classify the byte against the pending sequence.
  always_comb begin
    ent       = entity_for(mode, in_byte);
    pending   = (awaited != 2'd0);
    is_cont   = (in_byte[7:6] == 2'b10);
    complete  = !ent.hit && pending && is_cont && (awaited == 2'd1);
    absorb    = !ent.hit && pending && is_cont && (awaited == 2'd2);
    flush     = pending && (ent.hit || !is_cont);
    new_lead2 = !ent.hit && (in_byte[7:5] == 3'b110);
    new_lead3 = !ent.hit && (in_byte[7:4] == 4'b1110);
  end

  // Partial flush prefix and the segment for the new byte.
  always_comb begin
    pre[0]  = latin1_hi(held_lead);
    pre[1]  = latin1_lo(held_lead);
    pre[2]  = latin1_hi(held_cont);
    pre[3]  = latin1_lo(held_cont);
    pre_len = flush ? (cont_held ? 3'd4 : 3'd2) : 3'd0;
    seg     = '0;
    seg_len = 3'd0;
    if (ent.hit) begin
      seg     = ent.text;
      seg_len = ent.len;
    end else if (in_byte[7] == 1'b0) begin
      seg[0]  = in_byte;
      seg_len = 3'd1;
    end else if (new_lead2 || new_lead3) begin
      seg_len = 3'd0;
    end else begin
      seg[0]  = latin1_hi(in_byte);
      seg[1]  = latin1_lo(in_byte);
      seg_len = 3'd2;
    end
  end

  // Assemble the output block.
  always_comb begin
    burst = '0;
    j     = '0;
    if (complete) begin
      burst.data[0] = held_lead;
      burst.data[1] = cont_held ? held_cont : in_byte;
      burst.data[2] = in_byte;
      burst.len     = cont_held ? LenW'(3) : LenW'(2);
    end else if (!absorb) begin
      for (int i = 0; i < MaxOut; i++) begin
        j = LenW'(i) - LenW'(pre_len);
        if (LenW'(i) < LenW'(pre_len)) begin
          burst.data[i] = pre[i[1:0]];
        end else if (j < LenW'(6)) begin
          burst.data[i] = seg[j[2:0]];
        end
      end
      burst.len = LenW'(pre_len) + LenW'(seg_len);
    end
  end

  // Next state of the pending sequence.
  always_comb begin
    held_lead_next = held_lead;
    held_cont_next = held_cont;
    cont_held_next = cont_held;
    awaited_next   = awaited;
    if (complete) begin
      cont_held_next = 1'b0;
      awaited_next   = 2'd0;
    end else if (absorb) begin
      held_cont_next = in_byte;
      cont_held_next = 1'b1;
      awaited_next   = 2'd1;
    end else begin
      if (flush) begin
        cont_held_next = 1'b0;
        awaited_next   = 2'd0;
      end
      if (new_lead2 || new_lead3) begin
        held_lead_next = in_byte;
        cont_held_next = 1'b0;
        awaited_next   = new_lead3 ? 2'd2 : 2'd1;
      end
    end
  end

  // Control state is reset; held bytes are only read while a sequence is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      cont_held <= 1'b0;
      awaited   <= 2'd0;
    end else if (take) begin
      cont_held <= cont_held_next;
      awaited   <= awaited_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_lead <= held_lead_next;
      held_cont <= held_cont_next;
    end
  end

  // A held continuation only exists while the last byte of a 3-byte sequence is awaited.
  `ASSERT_CLKD(a_cont_held_awaits_one, clk, rst, cont_held |-> (awaited == 2'd1))

  // A sequence never waits for three continuation bytes.
  `ASSERT_CLKD(a_awaited_range, clk, rst, awaited != 2'd3)

endmodule

// ----- src/xeu_outbuf.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Holds one block of output bytes and sends it out one byte per cycle while m_tready is high.
module xeu_outbuf import xeu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  xeu_burst_t burst,
  output logic       free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [MaxOut-1:0][7:0] buffer;
  logic [LenW-1:0]        count;
  logic                   pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = buffer[0];
  assign m_tlast  = (count == LenW'(1));
  // A new block may enter once the last byte of the current one leaves.
  assign free     = (count == '0) || (m_tlast && m_tready);

  // Byte count is control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.len;
    end else if (pop) begin
      count <= count - LenW'(1);
    end
  end

  // Shift the bytes toward the head as each one is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= burst.data;
    end else if (pop) begin
      buffer <= {8'h00, buffer[MaxOut-1:1]};
    end
  end

  // A block is only loaded when the previous one is gone or leaving.
  `ASSERT_CLKD(a_load_when_free, clk, rst,
    load |-> ((count == '0) || ((count == LenW'(1)) && m_tready)))

  // A block never holds more bytes than the buffer.
  `ASSERT_CLKD(a_len_fits, clk, rst, load |-> (burst.len <= LenW'(MaxOut)))

  // Taking a byte that is not the last one leaves one fewer.
  `ASSERT_CLKD(a_count_steps, clk, rst,
    (pop && (count > LenW'(1))) |=> (count == $past(count) - LenW'(1)))

endmodule

// ----- src/xml_escape_utf8_repair.sv -----
`timescale 1ns / 1ps

// XML text escaper with UTF-8 repair. Each request on the input stream is one
// text byte; it causes zero to ten output bytes, and m_tlast marks the final
// byte caused by that request. The input byte is registered, expanded by a
// single combinational pass into a block of output bytes, and loaded into an
// output buffer that sends one byte per cycle while m_tready is high. A request
// is accepted in every cycle in which the buffer is empty or sending its last
// byte, so the buffer's one-byte-per-cycle drain sets the rate. Bytes that cause
// no output (a held UTF-8 lead or middle continuation) load an empty block and
// leave the buffer free for the next request. The user must see that escape_mode
// is written through cfg_wen/cfg_wdata while the block is idle; the block does not enforce it.
module xml_escape_utf8_repair import xeu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_run
  input  logic       cfg_wen,
  input  logic [1:0] cfg_wdata  // [1:0] escape_mode
);

  logic [1:0] mode;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       take;
  logic       free;
  xeu_burst_t burst;

  assign take     = in_valid && free;
  assign s_tready = !in_valid || take;

  // Escape mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cfg_wen) begin
      mode <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  xeu_expand u_expand (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .mode    (mode),
    .take    (take),
    .burst   (burst)
  );

  xeu_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .burst    (burst),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import xeu_pkg::*;

  // Row value meaning the expected bytes come from the predictor.
  localparam int FROM_MODEL = -1;
  // Cycles the block may still need after the last expected byte has come out.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int SEGMENTS = 7;
  localparam int SEGMENT_BYTES = 26;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_out_t;

  typedef struct {
    logic [1:0]            mode;
    logic [7:0]            in_byte;
    int                    n_typed;
    logic [8*MaxOut-1:0]   text;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_wen = 1'b0;
  logic [1:0] cfg_wdata = MODE_NONE;

  // Predictor state: escape mode and the pending UTF-8 sequence.
  logic [1:0]  mode_now = MODE_NONE;
  logic [7:0]  seq_lead = 8'h00;
  logic [7:0]  seq_tail [2];
  int unsigned tail_count = 0;
  int unsigned tail_left = 0;

  logic [7:0] step_out[$];
  text_out_t  expected_text[$];
  stim_row_t  stim_table[$];
  text_out_t  want;
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;

  xml_escape_utf8_repair DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Entity text for a byte under a mode, or an empty string if it passes.
  function automatic string entity_of(input logic [1:0] mode, input logic [7:0] b);
    entity_of = "";
    case (mode)
      MODE_STD: begin
        if (b == CH_AMP) entity_of = "&amp;";
        else if (b == CH_APOS) entity_of = "&apos;";
        else if (b == CH_LT) entity_of = "&lt;";
        else if (b == CH_GT) entity_of = "&gt;";
        else if (b == CH_QUOT) entity_of = "&quot;";
      end
      MODE_ATTR: begin
        if (b == CH_AMP) entity_of = "&amp;";
        else if (b == CH_LT) entity_of = "&lt;";
        else if (b == CH_QUOT) entity_of = "&quot;";
      end
      MODE_CHAR: begin
        if (b == CH_AMP) entity_of = "&amp;";
        else if (b == CH_LT) entity_of = "&lt;";
      end
      default: ;
    endcase
  endfunction

  // Latin-1 byte re-encoded as UTF-8; ASCII stays one byte.
  task automatic put_latin1(input logic [7:0] v);
    if (!v[7]) begin
      step_out.push_back(v);
    end else begin
      step_out.push_back({6'b110000, v[7:6]});
      step_out.push_back({2'b10, v[5:0]});
    end
  endtask

  // Emits the pending sequence, raw when complete, re-encoded otherwise.
  task automatic flush_sequence(input bit complete);
    int unsigned k;
    if (complete) begin
      step_out.push_back(seq_lead);
      for (k = 0; k < tail_count; k++) step_out.push_back(seq_tail[k]);
    end else begin
      put_latin1(seq_lead);
      for (k = 0; k < tail_count; k++) put_latin1(seq_tail[k]);
    end
    seq_lead = 8'h00;
    seq_tail[0] = 8'h00;
    seq_tail[1] = 8'h00;
    tail_count = 0;
    tail_left = 0;
  endtask

  // Works out the output bytes that one input byte causes, into step_out.
  task automatic escape_and_repair(input logic [7:0] b);
    string ent;
    int    k;
    ent = entity_of(mode_now, b);
    step_out.delete();
    if (ent.len() != 0) begin
      if (tail_left != 0) flush_sequence(1'b0);
      for (k = 0; k < ent.len(); k++) step_out.push_back(ent[k]);
    end else if (tail_left != 0 && b[7:6] == 2'b10) begin
      // Continuation byte of the pending sequence.
      if (tail_count < 2) begin
        seq_tail[tail_count] = b;
        tail_count++;
      end
      tail_left--;
      if (tail_left == 0) flush_sequence(1'b1);
    end else begin
      if (tail_left != 0) flush_sequence(1'b0);
      if (!b[7]) begin
        step_out.push_back(b);
      end else if (b[7:5] == 3'b110) begin
        seq_lead = b;
        tail_count = 0;
        tail_left = 1;
      end else if (b[7:4] == 4'b1110) begin
        seq_lead = b;
        tail_count = 0;
        tail_left = 2;
      end else begin
        put_latin1(b);
      end
    end
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [7:0] b, input int n,
                         input logic [8*MaxOut-1:0] text);
    stim_row_t row;
    row.mode = mode;
    row.in_byte = b;
    row.n_typed = n;
    row.text = text;
    stim_table.push_back(row);
  endtask

  // Sends one request and records its expected output bytes once accepted.
  // Called and left at a falling edge; valid stays high for the next request.
  task automatic send_text_byte(input logic [7:0] b, input int n_typed,
                                input logic [8*MaxOut-1:0] text);
    text_out_t w;
    int        k;
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    escape_and_repair(b);
    // Rows with typed bytes replace the predicted ones; state still advances.
    if (n_typed != FROM_MODEL) begin
      step_out.delete();
      for (k = 0; k < n_typed; k++) step_out.push_back(text[8*(n_typed-1-k) +: 8]);
    end
    for (k = 0; k < step_out.size(); k++) begin
      w.data = step_out[k];
      w.last = (k == step_out.size() - 1);
      expected_text.push_back(w);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // Writes the escape mode once the block has gone quiet.
  task automatic set_mode(input logic [1:0] m);
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    mode_now = m;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // One random run: mostly text and well-formed sequences, some broken ones.
  task automatic send_random_run();
    int         kind;
    int         tail;
    int         k;
    logic [7:0] r;
    kind = $urandom_range(99);
    r = 8'($urandom);
    if (kind < 30) begin
      send_text_byte({1'b0, r[6:0]}, FROM_MODEL, '0);
    end else if (kind < 45) begin
      case ($urandom_range(4))
        0: r = CH_AMP;
        1: r = CH_APOS;
        2: r = CH_LT;
        3: r = CH_GT;
        default: r = CH_QUOT;
      endcase
      send_text_byte(r, FROM_MODEL, '0);
    end else if (kind < 90) begin
      tail = $urandom_range(1, 2);
      if (tail == 1) r = {3'b110, r[4:0]};
      else r = {4'b1110, r[3:0]};
      send_text_byte(r, FROM_MODEL, '0);
      // Broken runs stop short, so the next run interrupts the sequence.
      if (kind >= 75) tail = $urandom_range(0, tail - 1);
      for (k = 0; k < tail; k++) begin
        r = 8'($urandom);
        send_text_byte({2'b10, r[5:0]}, FROM_MODEL, '0);
      end
    end else begin
      send_text_byte(r, FROM_MODEL, '0);
    end
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compares each output byte with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected output byte %h last %b", m_tdata, m_tlast);
      end else begin
        want = expected_text.pop_front();
        if (want.data !== m_tdata || want.last !== m_tlast) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin
    int         seg;
    logic [1:0] m;

    // Directed rows: extremes, every entity, held, completed and broken sequences.
    add_row(MODE_NONE, 8'h00, 1, 8'h00);
    add_row(MODE_NONE, CH_AMP, 1, CH_AMP);
    add_row(MODE_NONE, 8'h7F, 1, 8'h7F);
    add_row(MODE_NONE, 8'hFF, 2, {8'hC3, 8'hBF});
    add_row(MODE_NONE, 8'h80, 2, {8'hC2, 8'h80});
    add_row(MODE_NONE, 8'hC3, 0, '0);
    add_row(MODE_NONE, 8'hA9, FROM_MODEL, '0);
    add_row(MODE_NONE, 8'hE2, 0, '0);
    add_row(MODE_NONE, 8'h82, 0, '0);
    add_row(MODE_NONE, 8'hAC, FROM_MODEL, '0);
    add_row(MODE_STD, CH_AMP, 5, "&amp;");
    add_row(MODE_STD, CH_APOS, 6, "&apos;");
    add_row(MODE_STD, CH_LT, 4, "&lt;");
    add_row(MODE_STD, CH_GT, 4, "&gt;");
    add_row(MODE_STD, CH_QUOT, 6, "&quot;");
    // Overlong three-byte lead cut off by an entity: ten output bytes.
    add_row(MODE_STD, 8'hE0, 0, '0);
    add_row(MODE_STD, 8'h80, 0, '0);
    add_row(MODE_STD, CH_QUOT, FROM_MODEL, '0);
    add_row(MODE_ATTR, CH_QUOT, 6, "&quot;");
    add_row(MODE_ATTR, CH_GT, 1, CH_GT);
    add_row(MODE_ATTR, CH_APOS, 1, CH_APOS);
    // Overlong two-byte lead held across a mode change.
    add_row(MODE_ATTR, 8'hC0, 0, '0);
    add_row(MODE_CHAR, 8'h80, FROM_MODEL, '0);
    add_row(MODE_CHAR, CH_QUOT, 1, CH_QUOT);
    add_row(MODE_CHAR, CH_AMP, 5, "&amp;");
    add_row(MODE_CHAR, 8'hC5, 0, '0);
    add_row(MODE_CHAR, 8'h41, FROM_MODEL, '0);
    add_row(MODE_CHAR, 8'hF0, 2, {8'hC3, 8'hB0});

    gap_pct = 20;
    stall_pct = 64;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    set_mode(MODE_NONE);

    foreach (stim_table[i]) begin
      if (stim_table[i].mode != mode_now) set_mode(stim_table[i].mode);
      send_text_byte(stim_table[i].in_byte, stim_table[i].n_typed, stim_table[i].text);
    end

    // Random segments, each under its own mode; idling changes between groups.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        gap_pct = 20;
        stall_pct = 64;
      end else if (seg < 5) begin
        gap_pct = 64;
        stall_pct = 20;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      m = 2'($urandom);
      if (seg < 4) m = 2'(seg);
      set_mode(m);
      bytes_sent = 0;
      while (bytes_sent < SEGMENT_BYTES) send_random_run();
    end

    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- xml_escape_utf8_repair.f -----
+incdir+src
src/xeu_pkg.sv
src/xeu_expand.sv
src/xeu_outbuf.sv
src/xml_escape_utf8_repair.sv
test/tb.sv
